// File: src/obb_pair_collision_test_core_defines.svh
`ifndef OBB_PAIR_COLLISION_TEST_CORE_DEFINES_SVH
`define OBB_PAIR_COLLISION_TEST_CORE_DEFINES_SVH
// assertion helpers
`define OBB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obb check failed");
`define OBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obb check failed");
`endif

// File: src/obbc_pkg.sv
package obbc_pkg;
    localparam int CW = 24;
    localparam int SW = 16;
    localparam int TW = 16;
    localparam int QW = 15;
    localparam int PW = 48;
    localparam int XW = 56;

    typedef logic signed [QW+1:0] trig_t;

    function automatic logic [TW-1:0] sine_tab(input logic [5:0] i);
        logic [TW-1:0] r;
        begin
            unique case (i)
                6'd0: r = 16'd0;      6'd1: r = 16'd804;    6'd2: r = 16'd1606;
                6'd3: r = 16'd2404;   6'd4: r = 16'd3196;   6'd5: r = 16'd3981;
                6'd6: r = 16'd4756;   6'd7: r = 16'd5520;   6'd8: r = 16'd6270;
                6'd9: r = 16'd7005;   6'd10: r = 16'd7723;  6'd11: r = 16'd8423;
                6'd12: r = 16'd9102;  6'd13: r = 16'd9760;  6'd14: r = 16'd10394;
                6'd15: r = 16'd11003; 6'd16: r = 16'd11585; 6'd17: r = 16'd12140;
                6'd18: r = 16'd12665; 6'd19: r = 16'd13160; 6'd20: r = 16'd13623;
                6'd21: r = 16'd14053; 6'd22: r = 16'd14449; 6'd23: r = 16'd14811;
                6'd24: r = 16'd15137; 6'd25: r = 16'd15426; 6'd26: r = 16'd15679;
                6'd27: r = 16'd15893; 6'd28: r = 16'd16069; 6'd29: r = 16'd16207;
                6'd30: r = 16'd16305; 6'd31: r = 16'd16364; 6'd32: r = 16'd16384;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

    function automatic trig_t fx_sin(input logic [15:0] a);
        logic [1:0] quad;
        logic [14:0] u;
        logic [4:0] idx;
        logic [8:0] frac;
        logic [TW-1:0] t0;
        logic [TW-1:0] t1;
        logic [25:0] prod;
        logic [TW-1:0] s;
        begin
            quad = a[15:14];
            u = (quad[0]) ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
            idx = u[13:9];
            frac = u[8:0];
            t0 = sine_tab({1'b0, idx});
            t1 = sine_tab({1'b0, idx} + 6'd1);
            prod = 26'(t1 - t0) * 26'(frac) + 26'd256;
            s = u[14] ? 16'd16384 : t0 + 16'(prod >> 9);
            return quad[1] ? -trig_t'({1'b0, s}) : trig_t'({1'b0, s});
        end
    endfunction
endpackage

// File: src/obbc_trig.sv
module obbc_trig #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic [15:0]           heading,
    input  logic                  en,
    output obbc_pkg::trig_t       cos_v,
    output obbc_pkg::trig_t       sin_v
);
    import obbc_pkg::*;
    logic [15:0] q;
    assign q = (heading >> (16 - ANGLE_BITS)) << (16 - ANGLE_BITS);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_v <= fx_sin(q + 16'd16384);
            sin_v <= fx_sin(q);
        end
    end
endmodule

// File: src/obbc_proj.sv
module obbc_proj (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [obbc_pkg::PW-1:0]    ux,
    input  logic signed [obbc_pkg::PW-1:0]    uy,
    input  logic signed [obbc_pkg::PW-1:0]    vx,
    input  logic signed [obbc_pkg::PW-1:0]    vy,
    input  obbc_pkg::trig_t                   c,
    input  obbc_pkg::trig_t                   s,
    output logic signed [obbc_pkg::XW-1:0]    lo,
    output logic signed [obbc_pkg::XW-1:0]    hi
);
    import obbc_pkg::*;
    // corner ux,uy +- vx,vy pairs; projection p = x*c + y*s
    logic signed [XW-1:0] pc, pv;
    logic signed [XW-1:0] pabs;
    assign pc = XW'(ux) * XW'(c) + XW'(uy) * XW'(s);
    assign pv = XW'(vx) * XW'(c) + XW'(vy) * XW'(s);
    assign pabs = pv[XW-1] ? -pv : pv;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo <= pc - pabs;
            hi <= pc + pabs;
        end
    end
endmodule

// File: src/obb_pair_collision_test_core.sv
// Oriented-box pair collision core (2D separating-axis test).
// Input channel: in_valid/in_stall with box A, box B and pair_skip fields.
// Output channel: out_valid/out_stall with collide and broad_pass.
// One result leaves for every transaction, in order.
// out_valid rises when an accepted transaction reaches the last pipeline
// stage; the result is taken on an edge with out_stall low.
// Throughput: one transaction per cycle unless a stalled output holds the pipeline;
// the four-stage pipeline (trig lookup, corner terms, axis projection, interval compare) sets it.
// A stalled output freezes the whole pipeline; in_stall is out_stall
// while the pipe holds valid data in its last stage.
// Reset empties the pipeline; no result is pending afterwards.
// Box corners are offsets from the centre as length*cos and width*sin
// terms; spans on each axis are centre projection +- the sum of the
// absolute offset projections, which equals the min/max over corners.
module obb_pair_collision_test_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [23:0]  a_x,
    input  logic signed [23:0]  a_y,
    input  logic [15:0]         a_length,
    input  logic [15:0]         a_width,
    input  logic [15:0]         a_heading,
    input  logic signed [23:0]  b_x,
    input  logic signed [23:0]  b_y,
    input  logic [15:0]         b_length,
    input  logic [15:0]         b_width,
    input  logic [15:0]         b_heading,
    input  logic                pair_skip,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                collide,
    output logic                broad_pass
);
    import obbc_pkg::*;
    `include "obb_pair_collision_test_core_defines.svh"

    logic adv;
    logic [3:0] v_reg;
    assign adv = !(v_reg[3] && out_stall);
    assign in_stall = !adv;
    assign out_valid = v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // stage 1
    trig_t ca, sa, cb, sb;
    obbc_trig #(.ANGLE_BITS(ANGLE_BITS)) u_ta (.clk(clk), .heading(a_heading), .en(adv),
        .cos_v(ca), .sin_v(sa));
    obbc_trig #(.ANGLE_BITS(ANGLE_BITS)) u_tb (.clk(clk), .heading(b_heading), .en(adv),
        .cos_v(cb), .sin_v(sb));
    logic signed [24:0] dx_reg, dy_reg;
    logic [15:0] al1_reg, aw1_reg, bl1_reg, bw1_reg;
    logic b1_reg;
    logic signed [24:0] dx_n, dy_n;
    logic [25:0] adx, ady;
    assign dx_n = 25'(a_x) - 25'(b_x);
    assign dy_n = 25'(a_y) - 25'(b_y);
    assign adx = dx_n[24] ? 26'(-dx_n) : 26'(dx_n);
    assign ady = dy_n[24] ? 26'(-dy_n) : 26'(dy_n);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg <= !pair_skip && !((adx << 1) > 26'(a_length) + 26'(b_length))
                && !((ady << 1) > 26'(a_width) + 26'(b_width));
            dx_reg <= dx_n; dy_reg <= dy_n;
            al1_reg <= a_length; aw1_reg <= a_width;
            bl1_reg <= b_length; bw1_reg <= b_width;
        end
    end

    // stage 2: half-extent vectors (doubled, Q14); centres relative
    logic signed [PW-1:0] aux_reg, auy_reg, avx_reg, avy_reg;
    logic signed [PW-1:0] bux_reg, buy_reg, bvx_reg, bvy_reg;
    logic signed [PW-1:0] dcx_reg, dcy_reg;
    trig_t ca2_reg, sa2_reg, cb2_reg, sb2_reg;
    logic b2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aux_reg <= PW'($signed({1'b0, al1_reg})) * PW'(ca);
            auy_reg <= PW'($signed({1'b0, al1_reg})) * PW'(sa);
            avx_reg <= -(PW'($signed({1'b0, aw1_reg})) * PW'(sa));
            avy_reg <= PW'($signed({1'b0, aw1_reg})) * PW'(ca);
            bux_reg <= PW'($signed({1'b0, bl1_reg})) * PW'(cb);
            buy_reg <= PW'($signed({1'b0, bl1_reg})) * PW'(sb);
            bvx_reg <= -(PW'($signed({1'b0, bw1_reg})) * PW'(sb));
            bvy_reg <= PW'($signed({1'b0, bw1_reg})) * PW'(cb);
            dcx_reg <= PW'(dx_reg) <<< 15;
            dcy_reg <= PW'(dy_reg) <<< 15;
            ca2_reg <= ca; sa2_reg <= sa; cb2_reg <= cb; sb2_reg <= sb;
            b2_reg <= b1_reg;
        end
    end

    // stage 3: project both boxes onto four axes; A centre relative to B
    logic signed [XW-1:0] alo [4];
    logic signed [XW-1:0] ahi [4];
    logic signed [XW-1:0] blo [4];
    logic signed [XW-1:0] bhi [4];
    trig_t axc [4];
    trig_t axs [4];
    logic signed [PW-1:0] zero;
    assign zero = '0;
    assign axc[0] = ca2_reg;  assign axs[0] = sa2_reg;
    assign axc[1] = -sa2_reg; assign axs[1] = ca2_reg;
    assign axc[2] = cb2_reg;  assign axs[2] = sb2_reg;
    assign axc[3] = -sb2_reg; assign axs[3] = cb2_reg;
    // span of a box = centre +- (|u.axis| + |v.axis|); fold v into centre pass
    logic signed [XW-1:0] aulo [4];
    logic signed [XW-1:0] auhi [4];
    logic signed [XW-1:0] bulo [4];
    logic signed [XW-1:0] buhi [4];
    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_ax
            obbc_proj u_pa (.clk(clk), .en(adv), .ux(dcx_reg), .uy(dcy_reg),
                .vx(avx_reg), .vy(avy_reg), .c(axc[g]), .s(axs[g]),
                .lo(alo[g]), .hi(ahi[g]));
            obbc_proj u_pau (.clk(clk), .en(adv), .ux(zero), .uy(zero),
                .vx(aux_reg), .vy(auy_reg), .c(axc[g]), .s(axs[g]),
                .lo(aulo[g]), .hi(auhi[g]));
            obbc_proj u_pb (.clk(clk), .en(adv), .ux(zero), .uy(zero),
                .vx(bvx_reg), .vy(bvy_reg), .c(axc[g]), .s(axs[g]),
                .lo(blo[g]), .hi(bhi[g]));
            obbc_proj u_pbu (.clk(clk), .en(adv), .ux(zero), .uy(zero),
                .vx(bux_reg), .vy(buy_reg), .c(axc[g]), .s(axs[g]),
                .lo(bulo[g]), .hi(buhi[g]));
        end
    endgenerate
    logic b3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            b3_reg <= b2_reg;
    end

    // stage 4: interval compare
    logic [3:0] ov;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            ov[k] = !(((ahi[k] + auhi[k]) < (blo[k] + bulo[k]))
                || ((bhi[k] + buhi[k]) < (alo[k] + aulo[k])));
    end
    logic col_reg, bp_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bp_reg <= b3_reg;
            col_reg <= b3_reg && (&ov);
        end
    end
    assign collide = col_reg;
    assign broad_pass = bp_reg;

    `OBB_ASSERT_IMPL(a_col_needs_broad, out_valid && collide, broad_pass)
    `OBB_ASSERT_IMPL(a_stall_only_full, in_stall, out_valid && out_stall)
    `OBB_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(collide))
endmodule

// File: sim/obb_pair_collision_test_core_tb.sv
`timescale 1ns / 1ps

module obb_pair_collision_test_core_tb;

    typedef struct packed {
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic [15:0]        al;
        logic [15:0]        aw;
        logic [15:0]        ah;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic [15:0]        bl;
        logic [15:0]        bw;
        logic [15:0]        bh;
        logic               skip;
    } pair_t;

    typedef struct packed {
        logic collide;
        logic broad;
    } verdict_t;

    localparam int ANGLE_BITS = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [23:0] a_x;
    logic signed [23:0] a_y;
    logic [15:0] a_length;
    logic [15:0] a_width;
    logic [15:0] a_heading;
    logic signed [23:0] b_x;
    logic signed [23:0] b_y;
    logic [15:0] b_length;
    logic [15:0] b_width;
    logic [15:0] b_heading;
    logic pair_skip;
    logic out_valid;
    logic out_stall;
    logic collide;
    logic broad_pass;

    pair_t    pending_pairs[$];
    verdict_t expected_verdicts[$];
    int mismatch_count;
    int result_count;
    int hit_count;
    int broad_count;
    int idle_cycles;
    int send_gap;
    int recv_gap;
    bit stimulus_done;
    bit quiet_phase;
    bit drain_hold;

    int sine_q14[33] = '{
            0,   804,  1606,  2404,  3196,  3981,  4756,  5520,
         6270,  7005,  7723,  8423,  9102,  9760, 10394, 11003,
        11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
        15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
        16384
    };

    obb_pair_collision_test_core #(.ANGLE_BITS(ANGLE_BITS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_x(a_x), .a_y(a_y), .a_length(a_length), .a_width(a_width),
        .a_heading(a_heading),
        .b_x(b_x), .b_y(b_y), .b_length(b_length), .b_width(b_width),
        .b_heading(b_heading),
        .pair_skip(pair_skip),
        .out_valid(out_valid), .out_stall(out_stall),
        .collide(collide), .broad_pass(broad_pass)
    );

    function automatic longint quadrant_sine(int unsigned u);
        int unsigned idx;
        int unsigned frac;
        if (u >= 16384)
            return 16384;
        idx = (u >> 9) & 31;
        frac = u & 511;
        return longint'(sine_q14[idx]) +
            longint'((((sine_q14[idx + 1] - sine_q14[idx]) * frac) + 256) >> 9);
    endfunction

    function automatic longint table_sine(logic [15:0] angle);
        logic [1:0] quad;
        int unsigned u;
        longint s;
        quad = angle[15:14];
        u = 32'(angle[13:0]);
        s = quad[0] ? quadrant_sine(16384 - u) : quadrant_sine(u);
        return quad[1] ? -s : s;
    endfunction

    function automatic void box_span(longint cx, longint cy, longint len, longint wid,
                                     longint c, longint s, longint axx, longint axy,
                                     output longint lo, output longint hi);
        longint lx;
        longint ly;
        longint px;
        longint py;
        longint p;
        for (int i = 0; i < 4; i++)
        begin
            lx = (i == 0 || i == 3) ? len : -len;
            ly = (i < 2) ? wid : -wid;
            px = cx * 32768 + lx * c - ly * s;
            py = cy * 32768 + lx * s + ly * c;
            p = px * axx + py * axy;
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endfunction

    function automatic verdict_t judge_pair(pair_t p);
        verdict_t v;
        logic [15:0] ha;
        logic [15:0] hb;
        longint dx;
        longint dy;
        longint ca, sa, cb, sb;
        longint axx[4];
        longint axy[4];
        longint lo1, hi1, lo2, hi2;
        ha = (p.ah >> (16 - ANGLE_BITS)) << (16 - ANGLE_BITS);
        hb = (p.bh >> (16 - ANGLE_BITS)) << (16 - ANGLE_BITS);
        dx = longint'(p.ax) - longint'(p.bx);
        dy = longint'(p.ay) - longint'(p.by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        v.broad = !p.skip && !(2 * dx > longint'(p.al) + longint'(p.bl))
                  && !(2 * dy > longint'(p.aw) + longint'(p.bw));
        v.collide = v.broad;
        if (v.broad)
        begin
            ca = table_sine(ha + 16'd16384); sa = table_sine(ha);
            cb = table_sine(hb + 16'd16384); sb = table_sine(hb);
            axx[0] = ca;  axy[0] = sa;
            axx[1] = -sa; axy[1] = ca;
            axx[2] = cb;  axy[2] = sb;
            axx[3] = -sb; axy[3] = cb;
            for (int i = 0; i < 4; i++)
            begin
                box_span(p.ax, p.ay, p.al, p.aw, ca, sa, axx[i], axy[i], lo1, hi1);
                box_span(p.bx, p.by, p.bl, p.bw, cb, sb, axx[i], axy[i], lo2, hi2);
                if (hi1 < lo2 || hi2 < lo1)
                    v.collide = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int unsigned mode;
        p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            p.al = (mode < 2) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            p.aw = (mode < 2) ? 16'($urandom) : 16'($urandom_range(0, 1000));
            p.bl = (mode < 2) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            p.bw = (mode < 2) ? 16'($urandom) : 16'($urandom_range(0, 1000));
            p.ax = (mode < 2) ? 24'sd8388607 - 24'($urandom_range(0, 40000))
                              : 24'($urandom_range(0, 200000)) - 24'sd100000;
            p.ay = (mode < 2) ? -24'sd8388608 + 24'($urandom_range(0, 40000))
                              : 24'($urandom_range(0, 200000)) - 24'sd100000;
            p.bx = p.ax + 24'($urandom_range(0, 3000)) - 24'sd1500;
            p.by = p.ay + 24'($urandom_range(0, 2000)) - 24'sd1000;
            if (mode == 6)
            begin
                p.bx = p.ax + 24'((p.al + p.bl) / 2);
                p.by = p.ay;
                p.ah = 16'd0;
                p.bh = 16'd32768;
            end
            p.skip = ($urandom_range(0, 15) == 0);
        end
        return p;
    endfunction

    function automatic pair_t make_pair(int ax, int ay, int al, int aw, int ah,
                                        int bx, int by, int bl, int bw, int bh, bit sk);
        pair_t p;
        p.ax = 24'(ax); p.ay = 24'(ay); p.al = 16'(al); p.aw = 16'(aw); p.ah = 16'(ah);
        p.bx = 24'(bx); p.by = 24'(by); p.bl = 16'(bl); p.bw = 16'(bw); p.bh = 16'(bh);
        p.skip = sk;
        return p;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1024, 512, 0, 0, 0, 1024, 512, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1024, 512, 0, 0, 0, 1024, 512, 0, 1)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1024, 512, 0, 1024, 0, 1024, 512, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1024, 512, 0, 1025, 0, 1024, 512, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1024, 512, 0, 0, 512, 1024, 512, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 2000, 0, 8192, 0, 0, 0, 2000, 24576, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1000, 1000, 8192, 900, 900, 1000, 1000, 8192, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1000, 1000, 16384, 0, 0, 500, 500, 49152, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 1000, 1000, 65535, 300, 0, 600, 600, 32768, 0)};
        pending_pairs = {pending_pairs,
            make_pair(8388607, 8388607, 65535, 65535, 65535,
                      8388607, 8388607, 65535, 65535, 65535, 0)};
        pending_pairs = {pending_pairs,
            make_pair(-8388608, -8388608, 65535, 65535, 12345,
                      -8388608, -8388608, 65535, 65535, 54321, 0)};
        pending_pairs = {pending_pairs,
            make_pair(8388607, 0, 65535, 65535, 0, -8388608, 0, 65535, 65535, 0, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 65535, 65535, 5000, 40000, 40000, 65535, 65535, 60000, 0)};
        pending_pairs = {pending_pairs,
            make_pair(0, 0, 3000, 200, 4096, 1000, 1200, 3000, 200, 61440, 0)};
        for (int i = 0; i < 540; i++)
            pending_pairs = {pending_pairs, random_pair()};
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {a_x, a_y, a_length, a_width, a_heading} <= '0;
            {b_x, b_y, b_length, b_width, b_heading} <= '0;
            pair_skip <= 1'b0;
            send_gap <= 0;
            stimulus_done <= 1'b0;
            quiet_phase <= 1'b0;
            drain_hold <= 1'b0;
        end
        else
        begin
            automatic bit free = !in_valid || !in_stall;
            automatic pair_t p;
            if (free)
            begin
                if (in_valid)
                    expected_verdicts = {expected_verdicts,
                        judge_pair({a_x, a_y, a_length, a_width, a_heading,
                                    b_x, b_y, b_length, b_width, b_heading, pair_skip})};
                if (pending_pairs.size() == 300 && !drain_hold)
                begin
                    drain_hold <= 1'b1;
                    send_gap <= 1;
                    in_valid <= 1'b0;
                end
                else if (drain_hold && send_gap == 1)
                begin
                    in_valid <= 1'b0;
                    if (expected_verdicts.size() == 0 && !in_valid)
                        send_gap <= 0;
                end
                else if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_pairs.size() == 0)
                begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
                else if (!quiet_phase && $urandom_range(0, 9) == 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(1, 19);
                end
                else
                begin
                    p = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    a_x <= p.ax; a_y <= p.ay; a_length <= p.al; a_width <= p.aw;
                    a_heading <= p.ah;
                    b_x <= p.bx; b_y <= p.by; b_length <= p.bl; b_width <= p.bw;
                    b_heading <= p.bh;
                    pair_skip <= p.skip;
                    if (pending_pairs.size() < 80)
                        quiet_phase <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            mismatch_count <= 0;
            result_count <= 0;
            hit_count <= 0;
            broad_count <= 0;
        end
        else
        begin
            automatic verdict_t want;
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                hit_count <= hit_count + int'(collide);
                broad_count <= broad_count + int'(broad_pass);
                if (expected_verdicts.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result collide=%0b broad_pass=%0b",
                                 collide, broad_pass);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (want.collide !== collide || want.broad !== broad_pass)
                    begin
                        if (mismatch_count < 10)
                            $display("result %0d: collide exp %0b got %0b, %s %0b got %0b",
                                     result_count, want.collide, collide,
                                     "broad_pass exp", want.broad, broad_pass);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= (recv_gap > 1);
            end
            else if (!quiet_phase && $urandom_range(0, 11) == 0)
            begin
                recv_gap <= $urandom_range(1, 19);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding",
                         expected_verdicts.size());
                $display("TB_ERROR");
                $finish;
            end
            if (stimulus_done && expected_verdicts.size() == 0)
            begin
                repeat (10) @(posedge clk);
                $display("covered %0d box pairs: %0d passed the broad phase, %0d collided",
                         result_count, broad_count, hit_count);
                if (mismatch_count == 0 && expected_verdicts.size() == 0)
                    $display("TB_OK");
                else
                    $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
